// File: design/qtm_pkg.sv
// qtm_pkg: shared types and constants for the quadtree terrain mesh emitter
// no dependencies

package qtm_pkg;

   localparam int MAX_LEVEL_DEFAULT = 6;
   localparam int COORD_W = 7;
   localparam int VIDX_W = 13;
   localparam int LEVEL_W = 3;
   localparam int FLAG_W = 2;

   localparam logic [1:0] FLAG_CLEAR = 2'd0;
   localparam logic [1:0] FLAG_SPLIT = 2'd1;
   localparam logic [1:0] FLAG_CULLED = 2'd3;

   localparam logic [1:0] KIND_TRI = 2'd0;
   localparam logic [1:0] KIND_DIVIDED = 2'd1;
   localparam logic [1:0] KIND_CULLED = 2'd2;
   localparam logic [1:0] KIND_FRAME = 2'd3;

   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_NODE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_NREAD,
      ST_NWAIT,
      ST_DECIDE,
      ST_CHILD,
      ST_FILL,
      ST_FAN,
      ST_OUT
   } state_type;

endpackage

// File: design/qtm_ram.sv
// qtm_ram: generic synchronous ram with one write port and a registered read port
// no dependencies

module qtm_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4225
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: design/quadtree_terrain_mesh_emitter.sv
// quadtree_terrain_mesh_emitter: top level, sequencer around the vertex flag memory
// depends on qtm_pkg and qtm_ram

// Vertex flags (clear, split, culled) for a (2^MAX_LEVEL+1)-square grid live in
// one ram with a write port and a registered read port. After reset a clearing
// pass writes every entry with req_ready low. One item is handled at a time. A
// begin-frame item marks the root split and emits one result; a divided node reads
// its four neighbors, decides, writes four children and emits one result; a drawn
// node at the bottom level reads its neighbors, decides and emits its fan of 4 to
// 8 triangles, and a drawn node above the bottom level also writes its four
// children before the fan; a culled node writes every interior position
// ((2*inner-1)^2, off-grid positions included, their writes dropped) one at a time
// through the one memory write port, then emits one result. Each result sits in an
// output register until taken; a stalled output holds the sequencer where it emits.

module quadtree_terrain_mesh_emitter #(
   parameter int MAX_LEVEL = qtm_pkg::MAX_LEVEL_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [6:0]  req_center_x,
   input  logic [6:0]  req_center_y,
   input  logic [2:0]  req_node_level,
   input  logic        req_culled,
   input  logic        req_wants_divide,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [12:0] rsp_vertex_a,
   output logic [12:0] rsp_vertex_b,
   output logic [12:0] rsp_vertex_c,
   output logic        rsp_last
);

   localparam int GRID = (1 << MAX_LEVEL) + 1;
   localparam int DEPTH = GRID * GRID;
   localparam int AW = $clog2(DEPTH);
   // signed coordinate width: 7-bit center plus a step of up to 2^MAX_LEVEL
   localparam int CW = ((MAX_LEVEL > 7) ? MAX_LEVEL : 7) + 3;
   localparam int LW = $clog2(MAX_LEVEL + 1);
   localparam logic [AW-1:0] ROOT_ADDR = AW'((GRID - 1) / 2 * GRID + (GRID - 1) / 2);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic signed [CW-1:0] ONE = CW'(1);

   qtm_pkg::state_type state_ff, state_in;

   // item registers
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [CW-1:0] ns_ff, ns_in, inr_ff, inr_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic want_ff, want_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [2:0] cnt_ff, cnt_in;          // neighbor / child / side counter
   logic [3:0] nb_ff, nb_in;            // flagged neighbors, left top right bottom
   logic [3:0] ab_ff, ab_in;            // absent or flagged
   logic signed [CW-1:0] fr_ff, fr_in, fc_ff, fc_in;
   logic half_ff, half_in;              // second triangle of a split side
   logic [2:0] ntri_ff, ntri_in;
   logic [1:0] pk_ff, pk_in;            // kind of the pending single result

   // output registers
   logic ov_ff, ov_in;
   logic [1:0] ok_ff, ok_in;
   logic [12:0] oa_ff, oa_in, ob_ff, ob_in, oc_ff, oc_in;
   logic ol_ff, ol_in;

   // ram port
   logic we;
   logic [AW-1:0] waddr, raddr;
   logic [1:0] wdata, rdata;
   logic rd_ok_ff, rd_ok_in;

   qtm_ram #(.WIDTH(qtm_pkg::FLAG_W), .DEPTH(DEPTH)) u_flags (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(rdata)
   );

   function automatic logic on_grid(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy);
      return cx >= 0 && cy >= 0 && cx < CW'(GRID) && cy < CW'(GRID);
   endfunction

   function automatic logic [AW-1:0] addr_of(logic signed [CW-1:0] cx,
                                             logic signed [CW-1:0] cy);
      return AW'(cy) * AW'(GRID) + AW'(cx);
   endfunction

   function automatic logic [CW-1:0] sat(logic signed [CW-1:0] v);
      if (v < 0) return '0;
      if (v > CW'(GRID - 1)) return CW'(GRID - 1);
      return v;
   endfunction

   function automatic logic [12:0] vidx(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy);
      logic [CW+AW-1:0] p;
      p = (CW+AW)'(sat(cy)) * (CW+AW)'(GRID) + (CW+AW)'(sat(cx));
      return p[12:0];
   endfunction

   // by counter: neighbor 0 left, 1 top, 2 right, 3 bottom; child tl, tr, bl, br
   logic signed [CW-1:0] nx, ny, cx_c, cy_c, cs;
   always_comb begin
      nx = x_ff;
      ny = y_ff;
      case (cnt_ff[1:0])
         2'd0: nx = x_ff - ns_ff;
         2'd1: ny = y_ff - ns_ff;
         2'd2: nx = x_ff + ns_ff;
         default: ny = y_ff + ns_ff;
      endcase
      cs = inr_ff >>> 1;
      cx_c = cnt_ff[0] ? x_ff + cs : x_ff - cs;
      cy_c = cnt_ff[1] ? y_ff + cs : y_ff - cs;
   end

   // fan corners
   logic [12:0] vc, vlt, vrt, vlb, vrb, vm, s0, s1;
   always_comb begin
      vc = vidx(x_ff, y_ff);
      vlt = vidx(x_ff - inr_ff, y_ff - inr_ff);
      vrt = vidx(x_ff + inr_ff, y_ff - inr_ff);
      vlb = vidx(x_ff - inr_ff, y_ff + inr_ff);
      vrb = vidx(x_ff + inr_ff, y_ff + inr_ff);
      case (cnt_ff[1:0])
         2'd0: begin s0 = vlb; s1 = vlt; vm = vidx(x_ff - inr_ff, y_ff); end
         2'd1: begin s0 = vlt; s1 = vrt; vm = vidx(x_ff, y_ff - inr_ff); end
         2'd2: begin s0 = vrt; s1 = vrb; vm = vidx(x_ff + inr_ff, y_ff); end
         default: begin s0 = vrb; s1 = vlb; vm = vidx(x_ff, y_ff + inr_ff); end
      endcase
   end

   logic [LW-1:0] lvl_c;
   logic signed [CW-1:0] nstep_c;
   always_comb begin
      lvl_c = (int'(req_node_level) > MAX_LEVEL - 1) ? LW'(MAX_LEVEL - 1)
                                                     : LW'(req_node_level);
      nstep_c = CW'(1) <<< (LW'(MAX_LEVEL) - lvl_c);
   end

   logic out_free;
   assign out_free = !ov_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; ns_in = ns_ff; inr_in = inr_ff; lvl_in = lvl_ff;
      want_in = want_ff; clr_in = clr_ff; cnt_in = cnt_ff;
      nb_in = nb_ff; ab_in = ab_ff; fr_in = fr_ff; fc_in = fc_ff; half_in = half_ff;
      ntri_in = ntri_ff; pk_in = pk_ff;
      ov_in = ov_ff && !rsp_ready;
      ok_in = ok_ff; oa_in = oa_ff; ob_in = ob_ff; oc_in = oc_ff; ol_in = ol_ff;
      we = 1'b0; waddr = '0; wdata = qtm_pkg::FLAG_CLEAR;
      raddr = '0; rd_ok_in = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         qtm_pkg::ST_CLEAR: begin
            we = 1'b1; waddr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) state_in = qtm_pkg::ST_IDLE;
         end
         qtm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               x_in = CW'(req_center_x); y_in = CW'(req_center_y);
               lvl_in = lvl_c; ns_in = nstep_c; inr_in = nstep_c >>> 1;
               want_in = req_wants_divide;
               cnt_in = '0; nb_in = '0; ab_in = '0;
               if (req_command == qtm_pkg::CMD_FRAME) begin
                  we = 1'b1; waddr = ROOT_ADDR; wdata = qtm_pkg::FLAG_SPLIT;
                  pk_in = qtm_pkg::KIND_FRAME;
                  state_in = qtm_pkg::ST_OUT;
               end else if (req_culled) begin
                  fr_in = CW'(req_center_y) - (nstep_c >>> 1) + ONE;
                  fc_in = CW'(req_center_x) - (nstep_c >>> 1) + ONE;
                  state_in = qtm_pkg::ST_FILL;
               end else begin
                  state_in = qtm_pkg::ST_NREAD;
               end
            end
         end
         qtm_pkg::ST_FILL: begin
            // row-major sweep over the interior, off-grid writes dropped
            if (fr_ff <= y_ff + inr_ff - ONE) begin
               if (on_grid(fc_ff, fr_ff)) begin
                  we = 1'b1; waddr = addr_of(fc_ff, fr_ff); wdata = qtm_pkg::FLAG_CULLED;
               end
               if (fc_ff >= x_ff + inr_ff - ONE) begin
                  fc_in = x_ff - inr_ff + ONE;
                  fr_in = fr_ff + ONE;
               end else begin
                  fc_in = fc_ff + ONE;
               end
            end else begin
               pk_in = qtm_pkg::KIND_CULLED;
               state_in = qtm_pkg::ST_OUT;
            end
         end
         qtm_pkg::ST_NREAD: begin
            raddr = addr_of(nx, ny);
            rd_ok_in = on_grid(nx, ny);
            state_in = qtm_pkg::ST_NWAIT;
         end
         qtm_pkg::ST_NWAIT: begin
            nb_in[cnt_ff[1:0]] = rd_ok_ff && rdata != qtm_pkg::FLAG_CLEAR;
            ab_in[cnt_ff[1:0]] = !rd_ok_ff || rdata != qtm_pkg::FLAG_CLEAR;
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in = '0;
               state_in = qtm_pkg::ST_DECIDE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               state_in = qtm_pkg::ST_NREAD;
            end
         end
         qtm_pkg::ST_DECIDE: begin
            cnt_in = '0; half_in = 1'b0; ntri_in = '0;
            if (lvl_ff >= LW'(MAX_LEVEL - 1)) state_in = qtm_pkg::ST_FAN;
            else state_in = qtm_pkg::ST_CHILD;
         end
         qtm_pkg::ST_CHILD: begin
            if (on_grid(cx_c, cy_c)) begin
               we = 1'b1; waddr = addr_of(cx_c, cy_c);
               wdata = (&ab_ff && want_ff) ? qtm_pkg::FLAG_SPLIT : qtm_pkg::FLAG_CLEAR;
            end
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in = '0;
               if (&ab_ff && want_ff) begin
                  pk_in = qtm_pkg::KIND_DIVIDED;
                  state_in = qtm_pkg::ST_OUT;
               end else begin
                  state_in = qtm_pkg::ST_FAN;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         qtm_pkg::ST_FAN: begin
            if (out_free) begin
               ov_in = 1'b1; ok_in = qtm_pkg::KIND_TRI; oa_in = vc;
               if (!nb_ff[cnt_ff[1:0]]) begin
                  ob_in = s0; oc_in = s1;
               end else if (!half_ff) begin
                  ob_in = s0; oc_in = vm;
               end else begin
                  ob_in = vm; oc_in = s1;
               end
               ol_in = cnt_ff[1:0] == 2'd3 && (!nb_ff[3] || half_ff);
               ntri_in = ntri_ff + 1'b1;
               if (nb_ff[cnt_ff[1:0]] && !half_ff) begin
                  half_in = 1'b1;
               end else begin
                  half_in = 1'b0;
                  cnt_in = cnt_ff + 1'b1;
                  if (cnt_ff[1:0] == 2'd3) state_in = qtm_pkg::ST_IDLE;
               end
            end
         end
         qtm_pkg::ST_OUT: begin
            if (out_free) begin
               ov_in = 1'b1; ok_in = pk_ff;
               oa_in = '0; ob_in = '0; oc_in = '0; ol_in = 1'b1;
               state_in = qtm_pkg::ST_IDLE;
            end
         end
         default: state_in = qtm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qtm_pkg::ST_CLEAR;
         clr_ff <= '0;
         ov_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         ov_ff <= ov_in;
         rd_ok_ff <= rd_ok_in;
      end
      x_ff <= x_in; y_ff <= y_in; ns_ff <= ns_in; inr_ff <= inr_in; lvl_ff <= lvl_in;
      want_ff <= want_in; cnt_ff <= cnt_in; nb_ff <= nb_in;
      ab_ff <= ab_in; fr_ff <= fr_in; fc_ff <= fc_in; half_ff <= half_in;
      ntri_ff <= ntri_in; pk_ff <= pk_in;
      ok_ff <= ok_in; oa_ff <= oa_in; ob_ff <= ob_in; oc_ff <= oc_in; ol_ff <= ol_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_kind = ok_ff;
   assign rsp_vertex_a = oa_ff;
   assign rsp_vertex_b = ob_ff;
   assign rsp_vertex_c = oc_ff;
   assign rsp_last = ol_ff;

   // a stalled result stays valid and holds its kind and vertex b
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_vertex_b))
      else $error("result changed while stalled");

   // non-triangle results carry a zero vertex a and close the item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != qtm_pkg::KIND_TRI |-> rsp_last && rsp_vertex_a == '0)
      else $error("bad non-triangle result");

   // no item is accepted during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      state_ff == qtm_pkg::ST_CLEAR |-> !req_ready)
      else $error("accepted during clear");

   // a fan never exceeds eight triangles
   assert property (@(posedge clock) disable iff (reset)
      state_ff == qtm_pkg::ST_FAN && $past(state_ff) == qtm_pkg::ST_FAN && $past(out_free)
      |-> ntri_ff != 3'd0)
      else $error("fan overrun");

endmodule
